// ===== src/framebuffer_rotate_bitplane_readout_defines.svh =====
// Assertion macros for the checker of the frame store readout.
`ifndef FRAMEBUFFER_ROTATE_BITPLANE_READOUT_DEFINES_SVH
`define FRAMEBUFFER_ROTATE_BITPLANE_READOUT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FRBR_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("frbr check failed");

// The consequent must hold in the cycle after the antecedent.
`define FRBR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("frbr check failed");

`endif

// ===== src/frbr_pkg.sv =====
// Shared types, constants and helper functions of the frame store readout.
package frbr_pkg;

	// Frame geometry.
	localparam int ROWS      = 168;
	localparam int COLS      = 144;
	localparam int PIX_COUNT = ROWS * COLS;

	localparam int IDX_W   = 15;
	localparam int ROW_W   = $clog2(ROWS);
	localparam int COL_W   = (COLS > 1) ? $clog2(COLS) : 1;
	localparam int ADDR_W  = $clog2(PIX_COUNT);
	localparam int HALF    = ROWS / 2;
	localparam int YI_BASE = (ROWS - 1) & ~1;

	// Exact division of the read index by ROWS through a rounded-up reciprocal.
	localparam int DIV_SHIFT = IDX_W + ROW_W;
	localparam int DIV_RECIP = ((1 << DIV_SHIFT) + ROWS - 1) / ROWS;
	localparam int RECIP_W   = IDX_W + 1;
	localparam int PROD_W    = IDX_W + RECIP_W;

	localparam int CH_STEP = 255 / 3;

	localparam logic [5:0] LSB_MASK = 6'b010101;
	localparam logic [5:0] MSB_MASK = 6'b101010;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_READ  = 1'b1;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	typedef struct packed {
		logic               opcode;
		logic signed [15:0] pixel_x;
		logic signed [15:0] pixel_y;
		logic [23:0]        color_rgb;
		logic [IDX_W-1:0]   read_index;
	} req_t;

	typedef struct packed {
		logic [IDX_W-1:0] out_index;
		logic [5:0]       display_byte;
	} rsp_t;

	// One command for the back end: a pixel write or a two-row read.
	typedef struct packed {
		logic              is_read;
		logic              msb_plane;
		logic              row0_ok;
		logic              row1_ok;
		logic [ADDR_W-1:0] addr0;
		logic [ADDR_W-1:0] addr1;
		logic [5:0]        wdata;
		logic [IDX_W-1:0]  index;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_SECOND,
		BK_FINISH
	} back_state_t;

	function automatic logic [1:0] quant_channel(input logic [7:0] ch);
		logic [1:0] q;
		if (ch >= 8'(3 * CH_STEP)) begin
			q = 2'd3;
		end else if (ch >= 8'(2 * CH_STEP)) begin
			q = 2'd2;
		end else if (ch >= 8'(CH_STEP)) begin
			q = 2'd1;
		end else begin
			q = 2'd0;
		end
		return q;
	endfunction

	function automatic logic [5:0] quant_rgb(input logic [23:0] rgb);
		return {quant_channel(rgb[23:16]), quant_channel(rgb[15:8]), quant_channel(rgb[7:0])};
	endfunction

	function automatic logic [5:0] merge_planes(input logic [5:0] p0, input logic [5:0] p1,
			input logic msb);
		logic [5:0] b;
		if (msb) begin
			b = ((p0 & MSB_MASK) >> 1) | (p1 & MSB_MASK);
		end else begin
			b = (p0 & LSB_MASK) | ((p1 & LSB_MASK) << 1);
		end
		return b;
	endfunction

endpackage

// ===== src/framebuffer_rotate_bitplane_readout.sv =====
// Top level of the frame store with rotated, bit-plane-split readout.
//
// Requests arrive on req (valid/ready). A write item quantises an RGB888
// colour to two bits per channel and stores it at (pixel_x, pixel_y); writes
// outside the frame are dropped and produce no result. A read item gives a
// column-major display buffer byte index and produces exactly one result on
// rsp (valid/ready), carrying the index and the merged plane bits of two
// vertically adjacent pixels. Results leave in request order.
// A read passes through three front stages and the command queue, then
// makes two accesses to the single-port frame store. That port sets the
// rate: one write every cycle while no held result stops the back end;
// a read holds the port for both of its accesses.
// Reset clears the pipeline, the queue and the result valid flag; the frame
// store is not cleared and must be written before it is read.
// While the receiver holds rsp_ready low the result waits in its register,
// the back end goes on with writes but stops when the next read is done, and
// requests are still taken until the queue and the front stages are full.
module framebuffer_rotate_bitplane_readout (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  frbr_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output frbr_pkg::rsp_t rsp
);

	frbr_pkg::cmd_t   push_cmd, pop_cmd;
	frbr_pkg::qstat_t qstat;
	logic             push, pop;

	frbr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.push      (push),
		.push_cmd  (push_cmd),
		.qstat     (qstat)
	);

	frbr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.pop_cmd  (pop_cmd),
		.qstat    (qstat)
	);

	frbr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.qstat     (qstat),
		.pop       (pop),
		.cmd       (pop_cmd),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

// ===== src/frbr_front.sv =====
// Front end: accepts items, works out addresses and issues commands to the queue.
module frbr_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  frbr_pkg::req_t       req,
	output logic                 push,
	output frbr_pkg::cmd_t       push_cmd,
	input  frbr_pkg::qstat_t     qstat
);

	typedef struct packed {
		logic                        is_read;
		logic                        keep;
		logic [frbr_pkg::ADDR_W-1:0] addr;
		logic [5:0]                  wdata;
		logic [frbr_pkg::IDX_W-1:0]  index;
		logic [frbr_pkg::IDX_W-1:0]  quot;
	} s1_t;

	typedef struct packed {
		logic                        is_read;
		logic                        keep;
		logic [frbr_pkg::ADDR_W-1:0] addr;
		logic [5:0]                  wdata;
		logic [frbr_pkg::IDX_W-1:0]  index;
		logic [frbr_pkg::ROW_W-1:0]  yi;
		logic [frbr_pkg::COL_W-1:0]  col;
		logic                        msb_plane;
		logic                        row0_ok;
		logic                        row1_ok;
	} s2_t;

	s1_t            stage_s1, stage1_d;
	s2_t            stage_s2, stage2_d;
	frbr_pkg::cmd_t cmd_s3, cmd_d;
	logic           keep_s3;
	logic           valid_s1, valid_s2, valid_s3;
	logic           s1_free, s2_free, s3_free, s3_go;

	logic [frbr_pkg::PROD_W-1:0] div_prod;
	logic [frbr_pkg::IDX_W-1:0]  rem_full;
	logic [frbr_pkg::ROW_W-1:0]  rem, half_row, yi;
	logic [frbr_pkg::ROW_W:0]    yi_next;
	logic                        col_ok, msb;

	// Stage one: bounds check, write address, colour quantisation, read quotient.
	always_comb begin
		stage1_d.is_read = (req.opcode == frbr_pkg::OP_READ);
		stage1_d.keep    = stage1_d.is_read ||
			(req.pixel_x >= 16'sd0 && req.pixel_x < 16'(frbr_pkg::COLS) &&
			 req.pixel_y >= 16'sd0 && req.pixel_y < 16'(frbr_pkg::ROWS));
		stage1_d.addr    = frbr_pkg::ADDR_W'(req.pixel_y[frbr_pkg::ROW_W-1:0]) *
			frbr_pkg::ADDR_W'(frbr_pkg::COLS) +
			frbr_pkg::ADDR_W'(req.pixel_x[frbr_pkg::COL_W-1:0]);
		stage1_d.wdata   = frbr_pkg::quant_rgb(req.color_rgb);
		stage1_d.index   = req.read_index;
		div_prod         = frbr_pkg::PROD_W'(req.read_index) *
			frbr_pkg::PROD_W'(frbr_pkg::DIV_RECIP);
		stage1_d.quot    = frbr_pkg::IDX_W'(div_prod >> frbr_pkg::DIV_SHIFT);
	end

	// Stage two: row within the column, plane and the upper of the two frame rows.
	always_comb begin
		rem_full = stage_s1.index - stage_s1.quot * frbr_pkg::IDX_W'(frbr_pkg::ROWS);
		rem      = rem_full[frbr_pkg::ROW_W-1:0];
		msb      = (rem >= frbr_pkg::ROW_W'(frbr_pkg::HALF));
		half_row = msb ? rem - frbr_pkg::ROW_W'(frbr_pkg::HALF) : rem;
		yi       = frbr_pkg::ROW_W'(frbr_pkg::YI_BASE) - (half_row << 1);
		yi_next  = (frbr_pkg::ROW_W + 1)'(yi) + (frbr_pkg::ROW_W + 1)'(1);
		col_ok   = (stage_s1.quot < frbr_pkg::IDX_W'(frbr_pkg::COLS));

		stage2_d.is_read   = stage_s1.is_read;
		stage2_d.keep      = stage_s1.keep;
		stage2_d.addr      = stage_s1.addr;
		stage2_d.wdata     = stage_s1.wdata;
		stage2_d.index     = stage_s1.index;
		stage2_d.yi        = yi;
		stage2_d.col       = stage_s1.quot[frbr_pkg::COL_W-1:0];
		stage2_d.msb_plane = msb;
		stage2_d.row0_ok   = col_ok;
		stage2_d.row1_ok   = col_ok && (yi_next < (frbr_pkg::ROW_W + 1)'(frbr_pkg::ROWS));
	end

	// Stage three: memory addresses of the two rows of a read, or the write address.
	always_comb begin
		cmd_d.is_read   = stage_s2.is_read;
		cmd_d.msb_plane = stage_s2.msb_plane;
		cmd_d.row0_ok   = stage_s2.row0_ok;
		cmd_d.row1_ok   = stage_s2.row1_ok;
		cmd_d.wdata     = stage_s2.wdata;
		cmd_d.index     = stage_s2.index;
		if (stage_s2.is_read) begin
			cmd_d.addr0 = frbr_pkg::ADDR_W'(stage_s2.yi) * frbr_pkg::ADDR_W'(frbr_pkg::COLS) +
				frbr_pkg::ADDR_W'(stage_s2.col);
		end else begin
			cmd_d.addr0 = stage_s2.addr;
		end
		cmd_d.addr1 = cmd_d.addr0 + frbr_pkg::ADDR_W'(frbr_pkg::COLS);
	end

	// Writes that miss the frame leave stage three without entering the queue.
	assign s3_go     = valid_s3 && (!keep_s3 || !qstat.full);
	assign push      = valid_s3 && keep_s3 && !qstat.full;
	assign push_cmd  = cmd_s3;
	assign s3_free   = !valid_s3 || s3_go;
	assign s2_free   = !valid_s2 || s3_free;
	assign s1_free   = !valid_s1 || s2_free;
	assign req_ready = s1_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (s1_free) begin
				valid_s1 <= req_valid;
			end
			if (s2_free) begin
				valid_s2 <= valid_s1;
			end
			if (s3_free) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_free && req_valid) begin
			stage_s1 <= stage1_d;
		end
		if (s2_free && valid_s1) begin
			stage_s2 <= stage2_d;
		end
		if (s3_free && valid_s2) begin
			cmd_s3  <= cmd_d;
			keep_s3 <= stage_s2.keep;
		end
	end

endmodule

// ===== src/frbr_queue.sv =====
// Short command queue between the front end and the back end.
module frbr_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  frbr_pkg::cmd_t   push_cmd,
	input  logic             pop,
	output frbr_pkg::cmd_t   pop_cmd,
	output frbr_pkg::qstat_t qstat
);

	frbr_pkg::cmd_t              slot_q [frbr_pkg::QUEUE_DEPTH];
	logic [frbr_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [frbr_pkg::QPTR_W:0]   count_q;
	logic                        do_push, do_pop;

	assign qstat.full  = (count_q == (frbr_pkg::QPTR_W + 1)'(frbr_pkg::QUEUE_DEPTH));
	assign qstat.empty = (count_q == '0);
	assign do_push     = push && !qstat.full;
	assign do_pop      = pop && !qstat.empty;
	assign pop_cmd     = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == frbr_pkg::QPTR_W'(frbr_pkg::QUEUE_DEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == frbr_pkg::QPTR_W'(frbr_pkg::QUEUE_DEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

// ===== src/frbr_back.sv =====
// Back end: frame store memory, command sequencer and result register.
module frbr_back (
	input  logic             clk,
	input  logic             arst_n,
	input  frbr_pkg::qstat_t qstat,
	output logic             pop,
	input  frbr_pkg::cmd_t   cmd,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output frbr_pkg::rsp_t   rsp
);

	logic [5:0] mem [frbr_pkg::PIX_COUNT];
	logic [5:0] rdata_q, p0_q;

	frbr_pkg::back_state_t       state_q, state_d;
	frbr_pkg::cmd_t              cur_q;
	frbr_pkg::rsp_t              rsp_q;
	logic                        rsp_valid_q;
	logic                        out_free, issue;
	logic                        mem_we, mem_re, load_cur, load_p0, load_rsp;
	logic [frbr_pkg::ADDR_W-1:0] mem_addr;
	logic [5:0]                  pix0, pix1;

	assign out_free = !rsp_valid_q || rsp_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			frbr_pkg::BK_IDLE: begin
				if (!qstat.empty) begin
					state_d = cmd.is_read ? frbr_pkg::BK_SECOND : frbr_pkg::BK_IDLE;
				end
			end
			frbr_pkg::BK_SECOND: begin
				state_d = frbr_pkg::BK_FINISH;
			end
			frbr_pkg::BK_FINISH: begin
				if (out_free) begin
					if (!qstat.empty) begin
						state_d = cmd.is_read ? frbr_pkg::BK_SECOND : frbr_pkg::BK_IDLE;
					end else begin
						state_d = frbr_pkg::BK_IDLE;
					end
				end
			end
			default: begin
				state_d = frbr_pkg::BK_IDLE;
			end
		endcase
	end

	// The memory port takes the next command's first access while the finished
	// read hands its result over.
	always_comb begin
		issue    = 1'b0;
		load_p0  = 1'b0;
		load_rsp = 1'b0;
		unique case (state_q)
			frbr_pkg::BK_IDLE: begin
				issue = !qstat.empty;
			end
			frbr_pkg::BK_SECOND: begin
				load_p0 = 1'b1;
			end
			frbr_pkg::BK_FINISH: begin
				load_rsp = out_free;
				issue    = out_free && !qstat.empty;
			end
			default: begin
				issue = 1'b0;
			end
		endcase
		pop      = issue;
		load_cur = issue && cmd.is_read;
		mem_we   = issue && !cmd.is_read;
		mem_re   = load_cur || load_p0;
		mem_addr = issue ? cmd.addr0 : cur_q.addr1;
	end

	assign pix0 = cur_q.row0_ok ? p0_q : 6'd0;
	assign pix1 = cur_q.row1_ok ? rdata_q : 6'd0;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= cmd.wdata;
		end
		if (mem_re) begin
			rdata_q <= mem[mem_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (load_cur) begin
			cur_q <= cmd;
		end
		if (load_p0) begin
			p0_q <= rdata_q;
		end
		if (load_rsp) begin
			rsp_q.out_index    <= cur_q.index;
			rsp_q.display_byte <= frbr_pkg::merge_planes(pix0, pix1, cur_q.msb_plane);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= frbr_pkg::BK_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ===== src/frbr_checker.sv =====
// Port-level checker for the frame store readout, bound to the top level.
`include "framebuffer_rotate_bitplane_readout_defines.svh"

module frbr_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_ready,
	input frbr_pkg::req_t req,
	input logic           rsp_valid,
	input logic           rsp_ready,
	input frbr_pkg::rsp_t rsp
);

	logic [3:0] pending_q;
	logic       read_in, rsp_out, past_frame;

	assign read_in = req_valid && req_ready && (req.opcode == frbr_pkg::OP_READ);
	assign rsp_out = rsp_valid && rsp_ready;

	// An index beyond the last column of the frame always reads as a blank byte.
	assign past_frame = rsp_valid &&
		(32'(rsp.out_index) >= 32'(frbr_pkg::PIX_COUNT));

	// Reads taken whose results have not yet been delivered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (read_in && !rsp_out) begin
			pending_q <= pending_q + 1'b1;
		end else if (rsp_out && !read_in) begin
			pending_q <= pending_q - 1'b1;
		end
	end

	`FRBR_ASSERT_SAME(a_rsp_needs_read, clk, arst_n, rsp_valid, pending_q != 4'd0)
	`FRBR_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))
	`FRBR_ASSERT_SAME(a_blank_column, clk, arst_n, past_frame, rsp.display_byte == 6'd0)
	`FRBR_ASSERT_SAME(a_reset_quiet, clk, arst_n, $rose(arst_n), !rsp_valid)

endmodule

bind framebuffer_rotate_bitplane_readout frbr_checker u_checker (.*);

// ===== sim/tb_framebuffer_rotate_bitplane_readout.sv =====
// Self-checking testbench for the frame store with rotated, bit-plane-split readout.
`timescale 1ns / 100ps

module tb_framebuffer_rotate_bitplane_readout;

	localparam int ROWS_N       = frbr_pkg::ROWS;
	localparam int COLS_N       = frbr_pkg::COLS;
	localparam int PIXELS       = ROWS_N * COLS_N;
	localparam int HALF_ROWS    = ROWS_N / 2;
	localparam int TOP_PAIR_ROW = (ROWS_N - 1) & ~1;
	localparam int PAIRS        = COLS_N * HALF_ROWS;
	localparam int LEVEL_STEP   = 255 / 3;
	localparam int MAX_INDEX    = 32767;

	localparam logic [5:0] PLANE_LO = 6'b010101;
	localparam logic [5:0] PLANE_HI = 6'b101010;

	localparam int RAND_ITEMS  = 1030;
	localparam int CALM_ITEMS  = 120;
	localparam int HOLD_CYCLES = 160;
	localparam int BURST_READS = 40;
	localparam int DIR_ROWS    = 24;

	typedef struct {
		frbr_pkg::req_t item;
		bit             typed;
		logic [5:0]     want_byte;
	} stim_row_t;

	logic           clk = 1'b0;
	logic           arst_n;
	logic           req_valid;
	logic           req_ready;
	frbr_pkg::req_t req;
	logic           rsp_valid;
	logic           rsp_ready;
	frbr_pkg::rsp_t rsp;

	// Shadow copy of the frame, with a note of which pixels and row pairs hold data.
	logic [5:0]     shadow_pix [PIXELS];
	bit             pix_written [PIXELS];
	bit             pair_listed [PAIRS];
	int             readable_pairs[$];
	frbr_pkg::rsp_t pending_bytes[$];
	frbr_pkg::rsp_t oldest;
	int             err_count = 0;
	bit             calm = 1'b0;
	bit             gaps_on = 1'b1;
	bit             long_hold = 1'b0;

	framebuffer_rotate_bitplane_readout u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic [1:0] level_of(input logic [7:0] ch);
		return 2'(int'(ch) / LEVEL_STEP);
	endfunction

	function automatic logic [5:0] shadow_at(input int row, input int col);
		if (row < 0 || row >= ROWS_N || col < 0 || col >= COLS_N) begin
			return 6'd0;
		end
		return shadow_pix[row * COLS_N + col];
	endfunction

	// Updates the shadow frame with one item and works out the byte a read returns.
	function automatic void frame_update(input frbr_pkg::req_t r, output bit gives_byte,
			output frbr_pkg::rsp_t want);
		int         x, y, yi, col, rem, h, pid;
		bit         upper;
		logic [5:0] p0, p1, b;
		gives_byte = 1'b0;
		want = '0;
		if (r.opcode == frbr_pkg::OP_WRITE) begin
			x = $signed(r.pixel_x);
			y = $signed(r.pixel_y);
			if (x >= 0 && x < COLS_N && y >= 0 && y < ROWS_N) begin
				shadow_pix[y * COLS_N + x] = {level_of(r.color_rgb[23:16]),
					level_of(r.color_rgb[15:8]), level_of(r.color_rgb[7:0])};
				pix_written[y * COLS_N + x] = 1'b1;
				yi = y & ~1;
				pid = x * HALF_ROWS + (TOP_PAIR_ROW - yi) / 2;
				if (!pair_listed[pid] && pix_written[yi * COLS_N + x] &&
						(yi + 1 >= ROWS_N || pix_written[(yi + 1) * COLS_N + x])) begin
					pair_listed[pid] = 1'b1;
					readable_pairs.push_back(pid);
				end
			end
		end else begin
			col = int'(r.read_index) / ROWS_N;
			rem = int'(r.read_index) % ROWS_N;
			b = 6'd0;
			if (col < COLS_N) begin
				upper = rem >= HALF_ROWS;
				h = upper ? rem - HALF_ROWS : rem;
				yi = TOP_PAIR_ROW - 2 * h;
				p0 = shadow_at(yi, col);
				p1 = shadow_at(yi + 1, col);
				if (upper) begin
					b = ((p0 & PLANE_HI) >> 1) | (p1 & PLANE_HI);
				end else begin
					b = (p0 & PLANE_LO) | ((p1 & PLANE_LO) << 1);
				end
			end
			gives_byte = 1'b1;
			want.out_index = r.read_index;
			want.display_byte = b;
		end
	endfunction

	function automatic frbr_pkg::req_t make_write(input int x, input int y,
			input logic [23:0] c);
		frbr_pkg::req_t r;
		r.opcode = frbr_pkg::OP_WRITE;
		r.pixel_x = 16'(x);
		r.pixel_y = 16'(y);
		r.color_rgb = c;
		r.read_index = 15'($urandom);
		return r;
	endfunction

	function automatic frbr_pkg::req_t make_read(input int idx);
		frbr_pkg::req_t r;
		r.opcode = frbr_pkg::OP_READ;
		r.pixel_x = 16'($urandom);
		r.pixel_y = 16'($urandom);
		r.color_rgb = 24'($urandom);
		r.read_index = 15'(idx);
		return r;
	endfunction

	// Channels land near the quantiser thresholds now and then.
	function automatic logic [23:0] pick_colour();
		logic [23:0] c;
		c = 24'($urandom);
		for (int k = 0; k < 3; k++) begin
			if ($urandom_range(0, 3) == 0) begin
				c[8 * k +: 8] = 8'(LEVEL_STEP * int'($urandom_range(0, 3)) -
					int'($urandom_range(0, 1)));
			end
		end
		return c;
	endfunction

	function automatic int pair_index(input int pid, input bit upper);
		return (pid / HALF_ROWS) * ROWS_N + pid % HALF_ROWS + (upper ? HALF_ROWS : 0);
	endfunction

	task automatic offer(input frbr_pkg::req_t r, input bit typed, input logic [5:0] typed_byte);
		bit             gives_byte;
		frbr_pkg::rsp_t want;
		req_valid <= 1'b1;
		req <= r;
		do @(posedge clk); while (req_ready !== 1'b1);
		frame_update(r, gives_byte, want);
		if (gives_byte) begin
			if (typed) begin
				want.display_byte = typed_byte;
			end
			pending_bytes.push_back(want);
		end
		if (gaps_on && !calm && $urandom_range(0, 4) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n === 1'b1 && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
			if (pending_bytes.size() == 0) begin
				$display("%0t: unexpected result: index %0d byte 0x%02h", $time,
					rsp.out_index, rsp.display_byte);
				err_count++;
			end else begin
				oldest = pending_bytes.pop_front();
				if (rsp.out_index !== oldest.out_index) begin
					$display("%0t: out_index expected %0d, got %0d", $time,
						oldest.out_index, rsp.out_index);
					err_count++;
				end
				if (rsp.display_byte !== oldest.display_byte) begin
					$display("%0t: display_byte for index %0d expected 0x%02h, got 0x%02h",
						$time, oldest.out_index, oldest.display_byte, rsp.display_byte);
					err_count++;
				end
			end
		end
	end

	// Result side: random stalls, one long hold-off on request, none when calm.
	initial begin
		int stretch;
		rsp_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (long_hold) begin
				rsp_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				long_hold = 1'b0;
			end else if (!calm && $urandom_range(0, 2) == 0) begin
				rsp_ready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			stretch = ($urandom_range(0, 5) == 0) ? 80 : $urandom_range(1, 16);
			do begin
				@(posedge clk);
				stretch--;
			end while (stretch > 0 && !long_hold);
		end
	end

	initial begin
		stim_row_t      directed [DIR_ROWS];
		int             done_items, next_flip, choice, col, yi, pid, lo_first, x, y;
		bit             squeezed;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		done_items = 0;
		next_flip = 0;
		squeezed = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The bottom-left pair is white, so both planes read all ones. One dropped write
		// uses an address that would alias onto a written pixel if the bounds were wrong.
		directed = '{
			'{make_write(0, 166, 24'hFFFFFF), 1'b0, 6'd0},
			'{make_write(0, 167, 24'hFFFFFF), 1'b0, 6'd0},
			'{make_read(0), 1'b1, 6'd63},
			'{make_read(HALF_ROWS), 1'b1, 6'd63},
			'{make_read(PIXELS), 1'b1, 6'd0},
			'{make_read(MAX_INDEX), 1'b1, 6'd0},
			'{make_write(COLS_N - 1, 0, 24'h000000), 1'b0, 6'd0},
			'{make_write(COLS_N - 1, 1, 24'h555555), 1'b0, 6'd0},
			'{make_read(PIXELS - HALF_ROWS - 1), 1'b0, 6'd0},
			'{make_read(PIXELS - 1), 1'b0, 6'd0},
			'{make_write(COLS_N, 166, 24'h000000), 1'b0, 6'd0},
			'{make_write(-1, 167, 24'h000000), 1'b0, 6'd0},
			'{make_write(0, -32768, 24'h000000), 1'b0, 6'd0},
			'{make_write(32767, 5, 24'h000000), 1'b0, 6'd0},
			'{make_write(0, ROWS_N, 24'h000000), 1'b0, 6'd0},
			'{make_write(-32768, -1, 24'h000000), 1'b0, 6'd0},
			'{make_read(0), 1'b1, 6'd63},
			'{make_write(1, 10, 24'h55A9FF), 1'b0, 6'd0},
			'{make_write(1, 11, 24'hAA54FE), 1'b0, 6'd0},
			'{make_read(ROWS_N + 78), 1'b0, 6'd0},
			'{make_read(ROWS_N + 78 + HALF_ROWS), 1'b0, 6'd0},
			'{make_write(1, 10, 24'h000000), 1'b0, 6'd0},
			'{make_read(ROWS_N + 78), 1'b0, 6'd0},
			'{make_read(ROWS_N + 78 + HALF_ROWS), 1'b0, 6'd0}
		};
		foreach (directed[i]) begin
			offer(directed[i].item, directed[i].typed, directed[i].want_byte);
		end

		while (done_items < RAND_ITEMS) begin
			if (done_items >= RAND_ITEMS - CALM_ITEMS) begin
				calm = 1'b1;
			end
			if (done_items >= next_flip) begin
				gaps_on = $urandom_range(0, 2) != 0;
				next_flip = done_items + 64;
			end
			if (!squeezed && done_items >= 300) begin
				// Hold results back while reads keep coming, then drain completely.
				squeezed = 1'b1;
				long_hold = 1'b1;
				gaps_on = 1'b0;
				repeat (BURST_READS) begin
					pid = readable_pairs[$urandom_range(0, readable_pairs.size() - 1)];
					offer(make_read(pair_index(pid, $urandom_range(0, 1))), 1'b0, 6'd0);
				end
				done_items += BURST_READS;
				req_valid <= 1'b0;
				while (pending_bytes.size() != 0) @(posedge clk);
				@(posedge clk);
			end
			choice = $urandom_range(0, 99);
			if (choice < 45) begin
				col = ($urandom_range(0, 7) == 0) ? (COLS_N - 1) * $urandom_range(0, 1)
					: $urandom_range(0, COLS_N - 1);
				yi = TOP_PAIR_ROW - 2 * $urandom_range(0, HALF_ROWS - 1);
				lo_first = $urandom_range(0, 1);
				offer(make_write(col, yi + 1 - lo_first, pick_colour()), 1'b0, 6'd0);
				offer(make_write(col, yi + lo_first, pick_colour()), 1'b0, 6'd0);
				pid = col * HALF_ROWS + (TOP_PAIR_ROW - yi) / 2;
				offer(make_read(pair_index(pid, lo_first)), 1'b0, 6'd0);
				done_items += 3;
				if ($urandom_range(0, 1)) begin
					offer(make_read(pair_index(pid, !lo_first)), 1'b0, 6'd0);
					done_items++;
				end
			end else if (choice < 70) begin
				pid = readable_pairs[$urandom_range(0, readable_pairs.size() - 1)];
				offer(make_read(pair_index(pid, $urandom_range(0, 1))), 1'b0, 6'd0);
				done_items++;
			end else if (choice < 80) begin
				offer(make_read($urandom_range(PIXELS, MAX_INDEX)), 1'b0, 6'd0);
				done_items++;
			end else if (choice < 88) begin
				offer(make_write($urandom_range(0, COLS_N - 1), $urandom_range(0, ROWS_N - 1),
					pick_colour()), 1'b0, 6'd0);
				done_items++;
			end else begin
				// Off-frame write: one coordinate is out of range, the other anything.
				x = int'($urandom_range(0, 65535)) - 32768;
				y = int'($urandom_range(0, 65535)) - 32768;
				if ($urandom_range(0, 1)) begin
					x = $urandom_range(0, 1) ? int'($urandom_range(COLS_N, 32767))
						: int'($urandom_range(0, 32767)) - 32768;
				end else begin
					y = $urandom_range(0, 1) ? int'($urandom_range(ROWS_N, 32767))
						: int'($urandom_range(0, 32767)) - 32768;
				end
				offer(make_write(x, y, pick_colour()), 1'b0, 6'd0);
				done_items++;
			end
		end

		req_valid <= 1'b0;
		while (pending_bytes.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (err_count == 0) begin
			$display("tb_framebuffer_rotate_bitplane_readout: done, clean");
		end else begin
			$display("tb_framebuffer_rotate_bitplane_readout: done, errors");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("timeout with %0d results outstanding", pending_bytes.size());
		$display("tb_framebuffer_rotate_bitplane_readout: done, errors");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+src
src/frbr_pkg.sv
src/frbr_front.sv
src/frbr_queue.sv
src/frbr_back.sv
src/framebuffer_rotate_bitplane_readout.sv
src/frbr_checker.sv
sim/tb_framebuffer_rotate_bitplane_readout.sv
